// File: rtl/core/swmp_pkg.sv
// Shared constants and types for the strided window median pooling unit.
`timescale 1ns / 1ps
package swmp_pkg;
  localparam int unsigned NumRegs = 7;
  localparam logic [2:0] RegKernelWidth  = 3'd0;
  localparam logic [2:0] RegKernelHeight = 3'd1;
  localparam logic [2:0] RegStrideX      = 3'd2;
  localparam logic [2:0] RegStrideY      = 3'd3;
  localparam logic [2:0] RegImageWidth   = 3'd4;
  localparam logic [2:0] RegImageHeight  = 3'd5;
  localparam logic [2:0] RegPlaneCount   = 3'd6;
  localparam int unsigned MaxHeight = 1024;

  typedef struct packed {
    logic last_in_plane;
    logic last_in_set;
  } swmp_flags_t;
endpackage

// File: rtl/core/swmp_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module swmp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// File: rtl/core/strided_window_median_pool_unit.sv
// Top level of the strided window median pooling unit with arg-median output.
// The sample channel takes one word per accepted handshake, in raster order,
// row by row and plane after plane. Each sample is written into a line store
// of MAX_KERNEL rows held in a synchronous RAM. When a sample completes a
// window whose origin lies on the stride grid, the unit stops taking samples,
// reads the window out of the line store one element per cycle, then ranks
// each element against every element of the window one comparison per cycle
// and reports the first element whose descending rank covers floor(kW*kH/2).
// Candidates are ranked one after another, up to kW*kH of them per window.
// The result word sits in an output register until taken; while it waits the
// unit still takes samples that complete no window, and stalls on the next one
// that does. Reset returns the counters to zero and the configuration
// registers to their reset values; the stores need no clearing. A write to one
// of the seven configuration registers restarts the stream at the first pixel of plane zero.
`timescale 1ns / 1ps
module strided_window_median_pool_unit
  import swmp_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_KERNEL  = 8,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] median_value_o,
  output logic [3:0]                    row_offset_o,
  output logic [3:0]                    col_offset_o,
  output logic                          last_in_plane_o,
  output logic                          last_in_set_o
);
  localparam int unsigned KB = $clog2(MAX_KERNEL);
  localparam int unsigned KW = $clog2(MAX_KERNEL + 1);
  localparam int unsigned XB = $clog2(MAX_WIDTH);
  localparam int unsigned XW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LineDepth = MAX_KERNEL * MAX_WIDTH;
  localparam int unsigned LB = $clog2(LineDepth);
  localparam int unsigned WinDepth = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned WB = $clog2(WinDepth);
  localparam int unsigned NW = $clog2(WinDepth + 1);
  localparam int unsigned YW = 11;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoad  = 3'd1;
  localparam logic [2:0] StFetch = 3'd2;
  localparam logic [2:0] StCand  = 3'd3;
  localparam logic [2:0] StCmp   = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [3:0]  kw_reg_q, kh_reg_q, sx_reg_q, sy_reg_q;
  logic [10:0] iw_reg_q, ih_reg_q;
  logic [15:0] pc_reg_q;

  logic [KW-1:0] kw, kh;
  logic [3:0]    sx, sy;
  logic [XW-1:0] iw;
  logic [YW-1:0] ih;
  logic [15:0]   pc;

  always_comb begin
    if (kw_reg_q == 4'd0) kw = KW'(1);
    else if (32'(kw_reg_q) > MAX_KERNEL) kw = KW'(MAX_KERNEL);
    else kw = KW'(kw_reg_q);
    if (kh_reg_q == 4'd0) kh = KW'(1);
    else if (32'(kh_reg_q) > MAX_KERNEL) kh = KW'(MAX_KERNEL);
    else kh = KW'(kh_reg_q);
    sx = (sx_reg_q == 4'd0) ? 4'd1 : sx_reg_q;
    sy = (sy_reg_q == 4'd0) ? 4'd1 : sy_reg_q;
    if (iw_reg_q == 11'd0) iw = XW'(1);
    else if (32'(iw_reg_q) > MAX_WIDTH) iw = XW'(MAX_WIDTH);
    else iw = XW'(iw_reg_q);
    if (ih_reg_q == 11'd0) ih = YW'(1);
    else if (32'(ih_reg_q) > MaxHeight) ih = YW'(MaxHeight);
    else ih = ih_reg_q;
    pc = (pc_reg_q == 16'd0) ? 16'd1 : pc_reg_q;
  end

  // Position counters, stride phase counters and origin trackers.
  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;
  logic [15:0]   plane_q;
  logic [3:0]    phx_q, phy_q;
  logic [XW-1:0] ocol_q;
  logic [YW-1:0] orow_q;
  logic [KB-1:0] slot_q;

  logic [2:0] state_q;
  logic       cfg_fire, cfg_restart, in_fire, out_fire;
  logic       hit;
  logic       col_ok, row_ok;

  assign cfg_ready_o = (state_q == StIdle) && !out_valid_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_restart = cfg_fire && (32'(cfg_index_i) < NumRegs);

  // A window is complete at this pixel when the column and row phase
  // counters sit on the grid and enough pixels have passed.
  assign col_ok = (col_q + XW'(1) >= XW'(kw)) && (phx_q == 4'd0);
  assign row_ok = (row_q + YW'(1) >= YW'(kh)) && (phy_q == 4'd0);
  assign hit    = col_ok && row_ok;

  assign in_ready_o = (state_q == StIdle) && !cfg_valid_i && !(hit && out_valid_o);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;

  logic          win_end_col, win_end_row;
  assign win_end_col = (col_q + XW'(1) >= iw);
  assign win_end_row = (row_q + YW'(1) >= ih);

  // Line store addressing.
  logic          ls_we, ls_re;
  logic [LB-1:0] ls_waddr, ls_raddr;
  logic [SAMPLE_BITS-1:0] ls_rdata;

  // Window load and rank loop.
  logic [KB-1:0] ly_q, lx_q;
  logic [NW-1:0] lcnt_q;
  logic          lval_q;
  logic [WB-1:0] lwaddr_q;
  logic [NW-1:0] n_q;
  logic [NW-1:0] ci_q, cj_q;
  logic [KB-1:0] crow_q, ccol_q;
  logic [NW-1:0] gt_q, eq_q;
  logic signed [SAMPLE_BITS-1:0] cand_q;
  logic          rd_pend_q;
  logic [XW-1:0] wocol_q;
  logic [KB-1:0] woslot_q;
  swmp_flags_t   wflags_q;

  logic          wr_we, wr_re;
  logic [WB-1:0] wr_waddr, wr_raddr;
  logic [SAMPLE_BITS-1:0] wr_rdata;

  logic [NW-1:0] rank;
  assign rank = n_q >> 1;

  logic [KB:0]   slot_sum;
  logic [KB-1:0] rd_slot;
  assign slot_sum = {1'b0, woslot_q} + {1'b0, ly_q};
  assign rd_slot  = (slot_sum >= (KB + 1)'(MAX_KERNEL)) ?
                    KB'(slot_sum - (KB + 1)'(MAX_KERNEL)) : KB'(slot_sum);

  assign ls_we    = in_fire;
  assign ls_waddr = LB'(slot_q) * LB'(MAX_WIDTH) + LB'(col_q[XB-1:0]);
  assign ls_re    = (state_q == StLoad);
  assign ls_raddr = LB'(rd_slot) * LB'(MAX_WIDTH) + LB'(wocol_q) + LB'(lx_q);

  swmp_ram #(.Width(SAMPLE_BITS), .Depth(LineDepth)) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ls_we),
    .waddr_i(ls_waddr),
    .wdata_i(sample_i),
    .re_i   (ls_re),
    .raddr_i(ls_raddr),
    .rdata_o(ls_rdata)
  );

  logic [WB-1:0] cand_addr;
  logic          cand_wait;
  assign cand_addr = WB'(ci_q);
  assign cand_wait = lval_q && (lwaddr_q == cand_addr);
  assign wr_we     = lval_q;
  assign wr_waddr  = lwaddr_q;
  assign wr_re     = (state_q == StFetch) || (state_q == StCmp);
  assign wr_raddr  = (state_q == StFetch) ? cand_addr : WB'(cj_q);

  swmp_ram #(.Width(SAMPLE_BITS), .Depth(WinDepth)) u_window_ram (
    .clk_i  (clk_i),
    .we_i   (wr_we),
    .waddr_i(wr_waddr),
    .wdata_i(ls_rdata),
    .re_i   (wr_re),
    .raddr_i(wr_raddr),
    .rdata_o(wr_rdata)
  );

  logic signed [SAMPLE_BITS-1:0] cmp_val;
  assign cmp_val = wr_rdata;
  logic [NW-1:0] gt_d, eq_d;
  always_comb begin
    gt_d = gt_q;
    eq_d = eq_q;
    if (cmp_val > cand_q) gt_d = gt_q + NW'(1);
    else if (cmp_val == cand_q) eq_d = eq_q + NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_reg_q <= 4'd2;
      kh_reg_q <= 4'd2;
      sx_reg_q <= 4'd2;
      sy_reg_q <= 4'd2;
      iw_reg_q <= 11'd1024;
      ih_reg_q <= 11'd1024;
      pc_reg_q <= 16'd1;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        RegKernelWidth:  kw_reg_q <= cfg_data_i[3:0];
        RegKernelHeight: kh_reg_q <= cfg_data_i[3:0];
        RegStrideX:      sx_reg_q <= cfg_data_i[3:0];
        RegStrideY:      sy_reg_q <= cfg_data_i[3:0];
        RegImageWidth:   iw_reg_q <= cfg_data_i[10:0];
        RegImageHeight:  ih_reg_q <= cfg_data_i[10:0];
        RegPlaneCount:   pc_reg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Last origin bounds: iw - kw and ih - kh, the largest origins that fit. The
  // origin trackers at plane start are zero, so the last one is reached when
  // one more stride step would pass the bound.
  logic [XW:0] ccol_lim;
  logic [YW:0] crow_lim;
  assign ccol_lim = {1'b0, iw} - (XW + 1)'(kw);
  assign crow_lim = {1'b0, ih} - (YW + 1)'(kh);

  // Per-origin last flags evaluated against the remaining span.
  logic lastc_hit, lastr_hit;
  assign lastc_hit = ({1'b0, ocol_q} + (XW + 1)'(sx) > ccol_lim);
  assign lastr_hit = ({1'b0, orow_q} + (YW + 1)'(sy) > crow_lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      plane_q <= '0;
      phx_q   <= '0;
      phy_q   <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
      slot_q  <= '0;
      state_q <= StIdle;
      out_valid_o <= 1'b0;
      lval_q  <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      lval_q <= 1'b0;
      if (out_fire) out_valid_o <= 1'b0;
      if (cfg_restart) begin
        col_q <= '0; row_q <= '0; plane_q <= '0;
        phx_q <= '0; phy_q <= '0; ocol_q <= '0; orow_q <= '0; slot_q <= '0;
      end else if (in_fire) begin
        if (hit) begin
          wocol_q  <= ocol_q;
          woslot_q <= (slot_q >= KB'(kh - KW'(1))) ? slot_q - KB'(kh - KW'(1)) :
                      KB'(32'(slot_q) + MAX_KERNEL - 32'(kh) + 1);
          n_q      <= NW'(kw) * NW'(kh);
          wflags_q.last_in_plane <= lastc_hit && lastr_hit;
          wflags_q.last_in_set   <= lastc_hit && lastr_hit && (plane_q + 16'd1 == pc);
          ly_q <= '0; lx_q <= '0; lcnt_q <= '0; lwaddr_q <= '0;
          state_q <= StLoad;
        end
        if (col_q + XW'(1) >= XW'(kw)) begin
          if (phx_q == 4'd0) begin
            ocol_q <= ocol_q + XW'(sx);
          end
          phx_q <= (phx_q + 4'd1 == sx) ? 4'd0 : phx_q + 4'd1;
        end else begin
          phx_q <= (col_q + XW'(2) >= XW'(kw)) ? 4'd0 : phx_q;
        end
        if (win_end_col) begin
          col_q  <= '0;
          ocol_q <= '0;
          phx_q  <= (kw == KW'(1)) ? 4'd0 : 4'd1;
          slot_q <= (32'(slot_q) == MAX_KERNEL - 1) ? '0 : slot_q + KB'(1);
          if (row_q + YW'(1) >= YW'(kh)) begin
            if (phy_q == 4'd0) orow_q <= orow_q + YW'(sy);
            phy_q <= (phy_q + 4'd1 == sy) ? 4'd0 : phy_q + 4'd1;
          end else begin
            phy_q <= (row_q + YW'(2) >= YW'(kh)) ? 4'd0 : phy_q;
          end
          if (win_end_row) begin
            row_q  <= '0;
            orow_q <= '0;
            phy_q  <= (kh == KW'(1)) ? 4'd0 : 4'd1;
            slot_q <= '0;
            plane_q <= (plane_q + 16'd1 >= pc) ? 16'd0 : plane_q + 16'd1;
          end else begin
            row_q <= row_q + YW'(1);
          end
        end else begin
          col_q <= col_q + XW'(1);
        end
      end
      case (state_q)
        StLoad: begin
          lval_q   <= 1'b1;
          lwaddr_q <= WB'(lcnt_q);
          lcnt_q   <= lcnt_q + NW'(1);
          if (KW'(lx_q) + KW'(1) == kw) begin
            lx_q <= '0;
            ly_q <= ly_q + KB'(1);
          end else begin
            lx_q <= lx_q + KB'(1);
          end
          if (lcnt_q + NW'(1) == n_q) begin
            ci_q <= '0;
            crow_q <= '0;
            ccol_q <= '0;
            state_q <= StFetch;
          end
        end
        StFetch: begin
          if (!cand_wait) state_q <= StCand;
        end
        StCand: begin
          cand_q  <= wr_rdata;
          gt_q    <= '0;
          eq_q    <= '0;
          cj_q    <= '0;
          state_q <= StCmp;
          rd_pend_q <= 1'b0;
        end
        StCmp: begin
          if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
            cj_q <= cj_q + NW'(1);
          end else begin
            gt_q <= gt_d;
            eq_q <= eq_d;
            if (cj_q == n_q) begin
              state_q <= StDone;
            end else begin
              cj_q <= cj_q + NW'(1);
            end
            if (cj_q == n_q) rd_pend_q <= 1'b0;
          end
        end
        StDone: begin
          if (gt_q <= rank && rank < gt_q + eq_q) begin
            median_value_o  <= cand_q;
            row_offset_o    <= 4'(crow_q) + 4'd1;
            col_offset_o    <= 4'(ccol_q) + 4'd1;
            last_in_plane_o <= wflags_q.last_in_plane;
            last_in_set_o   <= wflags_q.last_in_set;
            out_valid_o     <= 1'b1;
            state_q         <= StIdle;
          end else begin
            ci_q <= ci_q + NW'(1);
            if (KW'(ccol_q) + KW'(1) == kw) begin
              ccol_q <= '0;
              crow_q <= crow_q + KB'(1);
            end else begin
              ccol_q <= ccol_q + KB'(1);
            end
            state_q <= StFetch;
          end
        end
        default: ;
      endcase
    end
  end

  // The compare walk reads one element ahead: the last element's read data is
  // compared while the index equals the window size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> state_q == StIdle)
    else $error("Sample taken while a window is being ranked.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> !out_valid_o)
    else $error("Ranking finished while a result word was still pending.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |-> !in_fire)
    else $error("Configuration write and sample taken together.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmp) |-> cj_q <= n_q)
    else $error("Compare index ran past the window.");
endmodule

// File: tb/tb_strided_window_median_pool_unit.sv
// Self-checking testbench for the strided window median pooling unit.
`timescale 1ns / 1ps
module tb_strided_window_median_pool_unit
  import swmp_pkg::*;
();

  localparam int unsigned LineWidth  = 1024;
  localparam int unsigned KernelMax  = 8;
  localparam int unsigned SettleWait = 50;
  localparam int unsigned ItemTarget = 1500;

  typedef struct packed {
    logic signed [15:0] value;
    logic [3:0]         row_off;
    logic [3:0]         col_off;
    logic               plane_end;
    logic               set_end;
  } median_word_t;

  typedef enum logic [1:0] {
    PLAN_CFG,
    PLAN_PREDICT,
    PLAN_TYPED,
    PLAN_NONE
  } plan_kind_e;

  typedef struct packed {
    plan_kind_e   kind;
    logic [2:0]   index;
    logic [15:0]  data;
    median_word_t want;
  } plan_row_t;

  localparam logic [2:0] RegBeyondList = 3'd7;

  localparam plan_row_t Plan [37] = '{
    '{PLAN_CFG, RegKernelWidth, 16'd1, '0},
    '{PLAN_CFG, RegKernelHeight, 16'd1, '0},
    '{PLAN_CFG, RegStrideX, 16'd1, '0},
    '{PLAN_CFG, RegStrideY, 16'd1, '0},
    '{PLAN_CFG, RegImageWidth, 16'd2, '0},
    '{PLAN_CFG, RegImageHeight, 16'd1, '0},
    '{PLAN_CFG, RegPlaneCount, 16'd1, '0},
    '{PLAN_TYPED, 3'd0, 16'h7FFF, '{16'sh7FFF, 4'd1, 4'd1, 1'b0, 1'b0}},
    '{PLAN_TYPED, 3'd0, 16'h8000, '{16'sh8000, 4'd1, 4'd1, 1'b1, 1'b1}},
    '{PLAN_TYPED, 3'd0, 16'h0000, '{16'sh0000, 4'd1, 4'd1, 1'b0, 1'b0}},
    '{PLAN_TYPED, 3'd0, 16'hFFFF, '{16'shFFFF, 4'd1, 4'd1, 1'b1, 1'b1}},
    '{PLAN_CFG, RegKernelWidth, 16'd3, '0},
    '{PLAN_CFG, RegImageWidth, 16'd3, '0},
    '{PLAN_NONE, 3'd0, 16'd5, '0},
    '{PLAN_NONE, 3'd0, 16'd5, '0},
    '{PLAN_TYPED, 3'd0, 16'd5, '{16'sd5, 4'd1, 4'd1, 1'b1, 1'b1}},
    '{PLAN_PREDICT, 3'd0, 16'd7, '0},
    '{PLAN_PREDICT, 3'd0, 16'd9, '0},
    '{PLAN_PREDICT, 3'd0, 16'd7, '0},
    '{PLAN_CFG, RegKernelWidth, 16'd0, '0},
    '{PLAN_CFG, RegKernelHeight, 16'd15, '0},
    '{PLAN_CFG, RegStrideX, 16'd0, '0},
    '{PLAN_CFG, RegStrideY, 16'd0, '0},
    '{PLAN_CFG, RegImageWidth, 16'd0, '0},
    '{PLAN_CFG, RegImageHeight, 16'd8, '0},
    '{PLAN_CFG, RegPlaneCount, 16'd0, '0},
    '{PLAN_PREDICT, 3'd0, 16'd3, '0},
    '{PLAN_PREDICT, 3'd0, 16'hFFFE, '0},
    '{PLAN_PREDICT, 3'd0, 16'd3, '0},
    '{PLAN_PREDICT, 3'd0, 16'd100, '0},
    '{PLAN_PREDICT, 3'd0, 16'hFFCE, '0},
    '{PLAN_PREDICT, 3'd0, 16'd3, '0},
    '{PLAN_PREDICT, 3'd0, 16'd0, '0},
    '{PLAN_PREDICT, 3'd0, 16'd3, '0},
    '{PLAN_CFG, RegBeyondList, 16'd5, '0},
    '{PLAN_CFG, RegImageHeight, 16'd1, '0},
    '{PLAN_NONE, 3'd0, 16'd2, '0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] median_value_o;
  logic [3:0]         row_offset_o;
  logic [3:0]         col_offset_o;
  logic               last_in_plane_o;
  logic               last_in_set_o;

  strided_window_median_pool_unit dut (.*);

  logic [15:0]        shadow_regs [NumRegs];
  logic signed [15:0] line_copy [KernelMax * LineWidth];
  int unsigned        col_pos, row_pos, plane_pos;
  median_word_t       pending_medians [$];
  int unsigned        errors, samples_sent, medians_seen, settings_used;
  bit                 steady_phase;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void reset_shadow();
    shadow_regs = '{16'd2, 16'd2, 16'd2, 16'd2, 16'd1024, 16'd1024, 16'd1};
    col_pos = 0;
    row_pos = 0;
    plane_pos = 0;
  endfunction

  function automatic void shadow_write(logic [2:0] index, logic [15:0] data);
    int unsigned bits;
    if (index >= NumRegs) return;
    bits = (index >= RegPlaneCount) ? 16 : ((index >= RegImageWidth) ? 11 : 4);
    shadow_regs[index] = 16'(32'(data) & ((32'd1 << bits) - 32'd1));
    col_pos = 0;
    row_pos = 0;
    plane_pos = 0;
  endfunction

  function automatic bit pool_step(logic signed [15:0] s, output median_word_t r);
    int unsigned        kw, kh, sx, sy, iw, ih, pc, orow, ocol, n, rank, best, gt, eq;
    logic signed [15:0] win [KernelMax * KernelMax];
    bit                 hit, plane_end;
    kw = clamp(shadow_regs[RegKernelWidth], 1, KernelMax);
    kh = clamp(shadow_regs[RegKernelHeight], 1, KernelMax);
    sx = clamp(shadow_regs[RegStrideX], 1, 15);
    sy = clamp(shadow_regs[RegStrideY], 1, 15);
    iw = clamp(shadow_regs[RegImageWidth], 1, LineWidth);
    ih = clamp(shadow_regs[RegImageHeight], 1, MaxHeight);
    pc = clamp(shadow_regs[RegPlaneCount], 1, 65535);
    r = '0;
    if (col_pos >= iw) col_pos = 0;
    if (row_pos >= ih) row_pos = 0;
    if (plane_pos >= pc) plane_pos = 0;
    line_copy[(row_pos % KernelMax) * LineWidth + col_pos] = s;
    hit = (row_pos + 1 >= kh) && (col_pos + 1 >= kw) &&
          ((row_pos + 1 - kh) % sy == 0) && ((col_pos + 1 - kw) % sx == 0);
    if (hit) begin
      orow = row_pos + 1 - kh;
      ocol = col_pos + 1 - kw;
      n = kw * kh;
      rank = n / 2;
      best = 0;
      for (int y = 0; y < kh; y++)
        for (int x = 0; x < kw; x++)
          win[y * kw + x] = line_copy[((orow + y) % KernelMax) * LineWidth + ocol + x];
      for (int i = 0; i < n; i++) begin
        gt = 0;
        eq = 0;
        for (int j = 0; j < n; j++) begin
          if (win[j] > win[i]) gt++;
          else if (win[j] == win[i]) eq++;
        end
        if (gt <= rank && rank < gt + eq) begin
          best = i;
          break;
        end
      end
      plane_end = (orow == ((ih - kh) / sy) * sy) && (ocol == ((iw - kw) / sx) * sx);
      r.value = win[best];
      r.row_off = 4'(best / kw + 1);
      r.col_off = 4'(best % kw + 1);
      r.plane_end = plane_end;
      r.set_end = plane_end && (plane_pos + 1 == pc);
    end
    col_pos++;
    if (col_pos >= iw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= ih) begin
        row_pos = 0;
        plane_pos++;
        if (plane_pos >= pc) plane_pos = 0;
      end
    end
    return hit;
  endfunction

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] index, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    shadow_write(index, data);
  endtask

  task automatic send_sample(logic [15:0] data, plan_kind_e kind, median_word_t want,
                             bit hold);
    int unsigned  gap;
    median_word_t predicted;
    bit           hit;
    cfg_valid_i <= 1'b0;
    gap = steady_phase ? 0 : $urandom_range(0, 7);
    if (hold) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (pending_medians.size() != 0);
    end else if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= data;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    samples_sent++;
    hit = pool_step(data, predicted);
    if (kind == PLAN_TYPED) pending_medians.push_back(want);
    else if (kind == PLAN_PREDICT && hit) pending_medians.push_back(predicted);
  endtask

  function automatic logic [15:0] draw_pixel(int unsigned mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 3) - 2);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic int unsigned draw_kernel();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(9, 15);
    if (r == 2) return $urandom_range(5, 8);
    return $urandom_range(1, 4);
  endfunction

  function automatic int unsigned draw_extent(int unsigned k_eff);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(1025, 2047);
    if (r == 2) return $urandom_range(1, k_eff);
    return k_eff + $urandom_range(0, (k_eff > 4) ? 3 : 12);
  endfunction

  task automatic run_phase(bit force_hold);
    int unsigned kw, kh, sx, sy, iw, ih, pc, total, mode;
    kw = draw_kernel();
    kh = draw_kernel();
    sx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
    sy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
    iw = draw_extent(clamp(kw, 1, KernelMax));
    ih = draw_extent(clamp(kh, 1, KernelMax));
    case ($urandom_range(0, 9))
      0: pc = 0;
      1: pc = 65535;
      default: pc = $urandom_range(1, 3);
    endcase
    settle();
    write_reg(RegKernelWidth, 16'(kw));
    write_reg(RegKernelHeight, 16'(kh));
    write_reg(RegStrideX, 16'(sx));
    write_reg(RegStrideY, 16'(sy));
    write_reg(RegImageWidth, 16'(iw));
    write_reg(RegImageHeight, 16'(ih));
    write_reg(RegPlaneCount, 16'(pc));
    settings_used++;
    total = clamp(iw, 1, LineWidth) * clamp(ih, 1, MaxHeight) * clamp(pc, 1, 3);
    if (total > 400) total = $urandom_range(50, 400);
    else total = total * $urandom_range(1, 2);
    mode = $urandom_range(0, 2);
    steady_phase = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < total; i++)
      send_sample(draw_pixel(mode), PLAN_PREDICT, '0,
                  (force_hold && i == total / 2) || $urandom_range(0, 199) == 0);
  endtask

  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      stall = steady_phase ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    median_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      medians_seen++;
      if (pending_medians.size() == 0) begin
        $error("unexpected result word: median %0d", median_value_o);
        errors++;
      end else begin
        want = pending_medians.pop_front();
        if (median_value_o !== want.value) begin
          $error("median_value: expected %0d, got %0d", want.value, median_value_o);
          errors++;
        end
        if (row_offset_o !== want.row_off) begin
          $error("row_offset: expected %0d, got %0d", want.row_off, row_offset_o);
          errors++;
        end
        if (col_offset_o !== want.col_off) begin
          $error("col_offset: expected %0d, got %0d", want.col_off, col_offset_o);
          errors++;
        end
        if (last_in_plane_o !== want.plane_end) begin
          $error("last_in_plane: expected %0b, got %0b", want.plane_end, last_in_plane_o);
          errors++;
        end
        if (last_in_set_o !== want.set_end) begin
          $error("last_in_set: expected %0b, got %0b", want.set_end, last_in_set_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #1_000_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    errors = 0;
    samples_sent = 0;
    medians_seen = 0;
    settings_used = 0;
    steady_phase = 1'b0;
    reset_shadow();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (Plan[i]) begin
      if (Plan[i].kind == PLAN_CFG) begin
        if (i > 0 && Plan[i - 1].kind != PLAN_CFG) settle();
        write_reg(Plan[i].index, Plan[i].data);
      end else begin
        send_sample(Plan[i].data, Plan[i].kind, Plan[i].want, 1'b0);
      end
    end
    run_phase(1'b1);
    while (samples_sent < ItemTarget) run_phase(1'b0);
    settle();
    if (pending_medians.size() != 0) begin
      $error("%0d result words never arrived", pending_medians.size());
      errors++;
    end
    $display("Run covered %0d samples over %0d random settings plus directed cases.",
             samples_sent, settings_used);
    $display("%0d median words were compared field by field.", medians_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
